// ===== rtl/ssa_pkg.sv =====
// shared types, codes and constants for the symbol sequence autocorrelation block
package ssa_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int ACTION_W = 2;
    localparam int SYMBOL_W = 3;
    localparam int LAG_W    = 12;
    localparam int CORR_W   = 13;

    localparam logic [ACTION_W-1:0] ACTION_CLEAR   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_APPEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_COMPUTE = 2'd2;

    localparam logic [SYMBOL_W-1:0] SYM_INVALID = 3'd7;

    localparam int CORR_MAX = 4095;
    localparam int CORR_MIN = -4096;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [SYMBOL_W-1:0]     symbol;
        logic signed [LAG_W-1:0] lag;
    } in_item_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] corr_value;
        logic                     positive;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic add;
        logic finish;
    } acc_ctrl_t;

endpackage

// ===== rtl/ssa_store.sv =====
// symbol store: one write port, two registered read ports
module ssa_store #(
    parameter int DEPTH = ssa_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [ssa_pkg::SYMBOL_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr_a,
    input  logic [AW-1:0]                 rd_addr_b,
    output logic [ssa_pkg::SYMBOL_W-1:0]  rd_data_a,
    output logic [ssa_pkg::SYMBOL_W-1:0]  rd_data_b
);
    import ssa_pkg::*;

    logic [SYMBOL_W-1:0] mem [DEPTH];
    logic [SYMBOL_W-1:0] rd_a_reg;
    logic [SYMBOL_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== rtl/ssa_accum.sv =====
// shared pair-cost accumulator, offset and saturation, result register
module ssa_accum #(
    parameter int DEPTH = ssa_pkg::DEPTH_DEFAULT,
    parameter int LW    = $clog2(DEPTH + 1),
    parameter int ACC_W = $clog2(DEPTH + 2049) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssa_pkg::acc_ctrl_t            acc_ctrl,
    input  logic signed [ACC_W-1:0]       init_value,
    input  logic [ssa_pkg::SYMBOL_W-1:0]  sym_a,
    input  logic [ssa_pkg::SYMBOL_W-1:0]  sym_b,
    input  logic [LW-1:0]                 seq_length,
    input  logic                          offset_enable,
    input  logic                          out_ready,
    output logic                          out_valid,
    output ssa_pkg::out_item_t            out_data,
    output logic                          out_free
);
    import ssa_pkg::*;

    localparam int RES_W = ACC_W + 2;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(CORR_MAX);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(CORR_MIN);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] cost;
    logic signed [RES_W-1:0] acc_ext;
    logic signed [RES_W-1:0] val;
    logic signed [RES_W-1:0] offset;
    logic signed [RES_W-1:0] res;
    logic signed [RES_W-1:0] res_sat;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    out_item_t               out_data_reg;

    // pair cost of two stored symbols
    always_comb
    begin
        if (sym_a == SYM_INVALID || sym_b == SYM_INVALID)
        begin
            cost = '1;
        end
        else if (sym_a == sym_b)
        begin
            cost = '0;
        end
        else
        begin
            cost = ACC_W'(1);
        end
    end

    always_comb
    begin
        priority if (acc_ctrl.load)
        begin
            acc_next = init_value;
        end
        else if (acc_ctrl.add)
        begin
            acc_next = acc_reg + cost;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_comb
    begin
        acc_ext = {{2{acc_reg[ACC_W-1]}}, acc_reg};
        val     = -acc_ext;
        offset  = offset_enable ? RES_W'({seq_length, 1'b0}) : '0;
        res     = val + offset;
        priority if (res > RES_MAX)
        begin
            res_sat = RES_MAX;
        end
        else if (res < RES_MIN)
        begin
            res_sat = RES_MIN;
        end
        else
        begin
            res_sat = res;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (acc_ctrl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (acc_ctrl.finish)
        begin
            out_data_reg.corr_value <= res_sat[CORR_W-1:0];
            out_data_reg.positive   <= acc_reg[ACC_W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/ssa_ctrl.sv =====
// sequencer: sequence length, store writes, pair walk and accumulator control
module ssa_ctrl #(
    parameter int DEPTH = ssa_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1),
    parameter int ACC_W = $clog2(DEPTH + 2049) + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ssa_pkg::in_item_t             in_data,
    input  logic                          out_free,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [ssa_pkg::SYMBOL_W-1:0]  wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr_a,
    output logic [AW-1:0]                 rd_addr_b,
    output ssa_pkg::acc_ctrl_t            acc_ctrl,
    output logic signed [ACC_W-1:0]       init_value,
    output logic [LW-1:0]                 seq_length
);
    import ssa_pkg::*;

    localparam int CW = ((LW > LAG_W) ? LW : LAG_W) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [LW-1:0]    seq_len_reg;
    logic [LW-1:0]    seq_len_next;
    logic [LAG_W-1:0] mag_reg;
    logic [LAG_W-1:0] mag_next;
    logic [LW-1:0]    pos_reg;
    logic [LW-1:0]    pos_next;
    logic             pend_reg;
    logic             accept;
    logic [CW-1:0]    mag_ext;
    logic [CW-1:0]    len_ext;
    logic [CW-1:0]    mag_min;
    logic [LW-1:0]    pos_plus;
    logic [LW-1:0]    pos_lagged;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign mag_ext    = CW'(mag_reg);
    assign len_ext    = CW'(seq_len_reg);
    assign mag_min    = (mag_ext < len_ext) ? mag_ext : len_ext;
    assign init_value = ACC_W'(mag_ext) + ACC_W'(mag_min);
    assign pos_plus   = pos_reg + 1'b1;
    assign pos_lagged = pos_reg - LW'(mag_reg);

    assign wr_en      = accept && (in_data.action == ACTION_APPEND)
                        && (len_ext < CW'(DEPTH));
    assign wr_addr    = seq_len_reg[AW-1:0];
    assign wr_data    = in_data.symbol;
    assign rd_en      = (state_reg == ST_RUN);
    assign rd_addr_a  = pos_reg[AW-1:0];
    assign rd_addr_b  = pos_lagged[AW-1:0];
    assign seq_length = seq_len_reg;

    always_comb
    begin
        state_next      = state_reg;
        seq_len_next    = seq_len_reg;
        mag_next        = mag_reg;
        pos_next        = pos_reg;
        acc_ctrl.load   = 1'b0;
        acc_ctrl.add    = pend_reg;
        acc_ctrl.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_data.action == ACTION_CLEAR)
                    begin
                        seq_len_next = '0;
                    end
                    else if (in_data.action == ACTION_APPEND)
                    begin
                        if (wr_en)
                        begin
                            seq_len_next = seq_len_reg + 1'b1;
                        end
                    end
                    else if (in_data.action == ACTION_COMPUTE)
                    begin
                        mag_next   = in_data.lag[LAG_W-1] ? (~in_data.lag + 1'b1)
                                                          : in_data.lag;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        seq_len_next = seq_len_reg;
                    end
                end
            end
            ST_LOAD:
            begin
                acc_ctrl.load = 1'b1;
                pos_next      = LW'(mag_reg);
                state_next    = (mag_ext < len_ext) ? ST_RUN : ST_DRAIN;
            end
            ST_RUN:
            begin
                pos_next = pos_plus;
                if (pos_plus == seq_len_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    acc_ctrl.finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seq_len_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seq_len_reg <= seq_len_next;
            pend_reg    <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        pos_reg <= pos_next;
    end

endmodule

// ===== rtl/symbol_sequence_autocorrelation_top.sv =====
// top level of the symbol sequence autocorrelation block
//
// in channel: in_valid/in_ready with in_data (action, symbol, lag); one beat per item.
// clear and append give no result; in_ready stays high.
// an append to a full sequence is dropped, action 3 is dropped.
// a compute beat walks the stored pairs one per cycle through one shared cost
// adder fed by the two read ports of the symbol store; in_ready is low from the
// beat until the result is written into the output register.
// out channel: out_valid/out_ready with out_data (corr_value, positive).
// the result register frees the input side: clear and append beats are taken while
// a result waits, a further compute holds in its last step until the result is taken.
// cfg_write_en/cfg_write_data set the offset_enable register; write it only when idle.
// reset clears the sequence length, offset_enable and all handshake state;
// store contents are left as they are, positions past the length are never read.
module symbol_sequence_autocorrelation_top #(
    parameter int DEPTH = ssa_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ssa_pkg::out_item_t out_data,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data
);
    import ssa_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int ACC_W = $clog2(DEPTH + 2049) + 1;

    logic                    offset_enable_reg;
    logic                    out_free;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [SYMBOL_W-1:0]     wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic [SYMBOL_W-1:0]     sym_a;
    logic [SYMBOL_W-1:0]     sym_b;
    acc_ctrl_t               acc_ctrl;
    logic signed [ACC_W-1:0] init_value;
    logic [LW-1:0]           seq_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            offset_enable_reg <= cfg_write_data;
        end
    end

    ssa_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW),
        .ACC_W (ACC_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_free   (out_free),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .acc_ctrl   (acc_ctrl),
        .init_value (init_value),
        .seq_length (seq_length)
    );

    ssa_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (sym_a),
        .rd_data_b (sym_b)
    );

    ssa_accum #(
        .DEPTH (DEPTH),
        .LW    (LW),
        .ACC_W (ACC_W)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .acc_ctrl      (acc_ctrl),
        .init_value    (init_value),
        .sym_a         (sym_a),
        .sym_b         (sym_b),
        .seq_length    (seq_length),
        .offset_enable (offset_enable_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .out_data      (out_data),
        .out_free      (out_free)
    );

endmodule

// ===== bench/ssa_checker.sv =====
// checker for the autocorrelation block: tracks the sequence, predicts each result beat and compares
module ssa_checker #(
    parameter int DEPTH = ssa_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  ssa_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  ssa_pkg::out_item_t out_data,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               closing,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);
    import ssa_pkg::*;

    logic [SYMBOL_W-1:0] seq_symbols [DEPTH];
    int                  seq_len = 0;
    logic                add_offset = 1'b0;
    out_item_t           awaited_corr [$];
    int                  errors = 0;
    int                  checked = 0;
    logic                closed = 1'b0;

    function automatic out_item_t predict_corr(input logic signed [LAG_W-1:0] lag);
        out_item_t res;
        int        shift;
        int        cost_sum;
        int        value;
        int        pos;
        shift = (lag < 0) ? -int'(lag) : int'(lag);
        cost_sum = 0;
        for (pos = 0; pos < seq_len + shift; pos++)
        begin
            if (pos >= seq_len || pos < shift)
                cost_sum += 1;
            else if (seq_symbols[pos] == SYM_INVALID || seq_symbols[pos - shift] == SYM_INVALID)
                cost_sum -= 1;
            else if (seq_symbols[pos] != seq_symbols[pos - shift])
                cost_sum += 1;
        end
        value = -cost_sum;
        res.positive = (value > 0);
        if (add_offset)
            value += 2 * seq_len;
        if (value > CORR_MAX)
            value = CORR_MAX;
        if (value < CORR_MIN)
            value = CORR_MIN;
        res.corr_value = CORR_W'(value);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            seq_len = 0;
            add_offset = 1'b0;
            awaited_corr.delete();
        end
        else
        begin
            // result side first, so an older expectation is matched before a new one is queued
            if (out_valid && out_ready)
            begin
                if (awaited_corr.size() == 0)
                begin
                    $error("result beat with nothing expected: corr_value %0d positive %0b",
                           $signed(out_data.corr_value), out_data.positive);
                    errors++;
                end
                else
                begin
                    want = awaited_corr.pop_front();
                    checked++;
                    if (out_data.corr_value !== want.corr_value)
                    begin
                        $error("corr_value mismatch: expected %0d, actual %0d",
                               $signed(want.corr_value), $signed(out_data.corr_value));
                        errors++;
                    end
                    if (out_data.positive !== want.positive)
                    begin
                        $error("positive mismatch: expected %0b, actual %0b",
                               want.positive, out_data.positive);
                        errors++;
                    end
                end
            end
            if (cfg_write_en)
                add_offset = cfg_write_data;
            if (in_valid && in_ready)
            begin
                case (in_data.action)
                    ACTION_CLEAR:
                        seq_len = 0;
                    ACTION_APPEND:
                        if (seq_len < DEPTH)
                        begin
                            seq_symbols[seq_len] = in_data.symbol;
                            seq_len++;
                        end
                    ACTION_COMPUTE:
                        awaited_corr.push_back(predict_corr(in_data.lag));
                    default:
                        ;
                endcase
            end
            if (closing && !closed)
            begin
                closed = 1'b1;
                if (awaited_corr.size() != 0)
                begin
                    $error("%0d correlation results never arrived", awaited_corr.size());
                    errors += awaited_corr.size();
                end
            end
        end
        fail_count   <= errors;
        pending      <= awaited_corr.size();
        results_seen <= checked;
    end

endmodule

// ===== bench/tb_top.sv =====
// testbench top: drives sequence edits, lag queries and offset settings, and gives the verdict
module tb_top;
    import ssa_pkg::*;

    localparam int     DEPTH       = DEPTH_DEFAULT;
    localparam int     PHASES      = 6;
    localparam int     PHASE_ITEMS = 90;
    localparam longint CYCLE_LIMIT = 8_000_000;

    localparam logic [ACTION_W-1:0] ACTION_IGNORED = 2'd3;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_write_en;
    logic      cfg_write_data;
    logic      closing;

    int     fail_count;
    int     pending;
    int     results_seen;
    longint cycles = 0;
    int     beats_sent = 0;
    int     computes_sent = 0;
    int     len_hint = 0;
    bit     calm = 1'b0;

    symbol_sequence_autocorrelation_top #(.DEPTH(DEPTH)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    ssa_checker #(.DEPTH(DEPTH)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .closing        (closing),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cycle limit reached before the run drained");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_lag(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 2 * len + 4) - (len + 2);
        if (r < 85)
            return $urandom_range(0, 6) - 3;
        return $urandom_range(0, 4095) - 2048;
    endfunction

    function automatic logic [SYMBOL_W-1:0] pick_symbol(input int mode);
        case (mode)
            0:       return SYMBOL_W'($urandom_range(0, 7));
            1:       return $urandom_range(0, 1) ? SYM_INVALID : SYMBOL_W'($urandom_range(0, 1));
            default: return SYMBOL_W'($urandom_range(0, 6));
        endcase
    endfunction

    task automatic send_op(input logic [ACTION_W-1:0] act, input logic [SYMBOL_W-1:0] sym,
                           input int lag);
        in_item_t item;
        int       gap;
        item.action = act;
        item.symbol = sym;
        item.lag    = LAG_W'(lag);
        gap = calm ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        if (act == ACTION_COMPUTE)
            computes_sent++;
        else if (act == ACTION_CLEAR)
            len_hint = 0;
        else if (act == ACTION_APPEND && len_hint < DEPTH)
            len_hint++;
    endtask

    // hold the sender until every awaited result beat has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_offset(input logic enable);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= enable;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin : sink
        int stall;
        out_ready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = gap_len();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 300) : $urandom_range(1, 4))
                @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int                  phase;
        int                  counted;
        int                  r;
        int                  mode;
        int                  n;
        int                  i;
        logic [ACTION_W-1:0] act;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        closing        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_offset(1'b0);

        // empty sequence, lag extremes, ignored action
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 0);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), -2048);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 2047);
        send_op(ACTION_IGNORED, SYMBOL_W'($urandom), $urandom);
        for (i = 0; i < 8; i++)
            send_op(ACTION_APPEND, SYMBOL_W'(i), $urandom);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 0);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 1);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), -1);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 8);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), DEPTH);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), -DEPTH);
        send_op(ACTION_CLEAR, SYM_INVALID, $urandom);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 3);
        send_op(ACTION_APPEND, SYM_INVALID, $urandom);
        send_op(ACTION_APPEND, SYM_INVALID, $urandom);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 0);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), -1);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_offset(phase % 2 == 0);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                calm = ($urandom_range(0, 6) == 0);
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    act = ACTION_W'($urandom_range(0, 3));
                    send_op(act, SYMBOL_W'($urandom), $urandom_range(0, 4095) - 2048);
                    if (act != ACTION_IGNORED)
                        counted++;
                end
                else
                begin
                    if (r >= 25 || len_hint > 150)
                    begin
                        send_op(ACTION_CLEAR, SYMBOL_W'($urandom), $urandom);
                        counted++;
                    end
                    mode = $urandom_range(0, 2);
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
                    repeat (n)
                    begin
                        send_op(ACTION_APPEND, pick_symbol(mode), $urandom);
                        counted++;
                    end
                    repeat ($urandom_range(1, 4))
                    begin
                        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), pick_lag(len_hint));
                        counted++;
                    end
                end
            end
            calm = 1'b0;
        end

        // lag extremes on the last sequence, then an empty sequence
        drain();
        set_offset(1'b0);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 0);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), 2047);
        send_op(ACTION_CLEAR, SYMBOL_W'($urandom), $urandom);
        send_op(ACTION_COMPUTE, SYMBOL_W'($urandom), -5);

        drain();
        repeat (DEPTH + 8) @(posedge clk);
        @(negedge clk);
        closing <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d beats, %0d of them lag queries, on empty and short sequences",
                 beats_sent, computes_sent);
        $display("%0d correlation results compared with offset both off and on", results_seen);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssa_pkg.sv
rtl/ssa_store.sv
rtl/ssa_accum.sv
rtl/ssa_ctrl.sv
rtl/symbol_sequence_autocorrelation_top.sv
bench/ssa_checker.sv
bench/tb_top.sv
